### src/atan2_polynomial_assert.svh
// Assertion macros for the arctangent block.
`ifndef ATAN2_POLYNOMIAL_ASSERT_SVH
`define ATAN2_POLYNOMIAL_ASSERT_SVH
`ifndef SYNTH
`define A2P_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define A2P_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define A2P_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define A2P_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### src/a2p_pkg.sv
// Shared types and constants of the arctangent block.
`timescale 1ns / 1ps
package a2p_pkg;
    localparam int COORD_WIDTH = 16;
    localparam int ANGLE_FRAC_BITS = 13;
    localparam int ANGLE_WIDTH = ANGLE_FRAC_BITS + 3;
    localparam int MAG_WIDTH = COORD_WIDTH;
    localparam int RATIO_FRAC = 16;
    localparam int RATIO_WIDTH = RATIO_FRAC + 1;
    localparam int DIV_STEPS = RATIO_WIDTH;
    localparam int NUM_CELLS = DIV_STEPS + 7;
    localparam int QW = 34;

    localparam logic signed [QW-1:0] K_C1 = -34'sd351782264;
    localparam logic signed [QW-1:0] K_C2 = 34'sd171062341;
    localparam logic signed [QW-1:0] K_C3 = -34'sd49925210;
    localparam logic [QW-1:0] K_HALF_PI = 34'd1686629713;
    localparam logic [QW-1:0] K_PI = 34'd3373259426;

    typedef enum logic [2:0] {
        OP_DIV, OP_SQ, OP_P1, OP_P2, OP_P3, OP_T, OP_SUM, OP_FOLD
    } cell_op_t;

    typedef struct packed {
        logic                    vld;
        logic                    xneg;
        logic                    yneg;
        logic                    swap;
        logic [MAG_WIDTH-1:0]    hi;
        logic [MAG_WIDTH:0]      rem;
        logic [RATIO_WIDTH-1:0]  quo;
        logic signed [QW-1:0]    big_a;
        logic signed [QW-1:0]    s;
        logic signed [QW-1:0]    acc;
    } cell_data_t;

    // Q.30 product rounded half up: floor((a*b + 2^29) / 2^30).
    function automatic logic signed [QW-1:0] qmul(input logic signed [QW-1:0] a,
                                                  input logic signed [QW-1:0] b);
        logic signed [2*QW-1:0] p;
        begin
            p = (2*QW)'(a) * (2*QW)'(b) + (2*QW)'(64'sd536870912);
            qmul = QW'(p >>> 30);
        end
    endfunction
endpackage

### src/a2p_cell.sv
// One cell of the arctangent chain: a divider step or a polynomial step.
`timescale 1ns / 1ps
module a2p_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  a2p_pkg::cell_op_t      op,
    input  a2p_pkg::cell_data_t    din,
    output a2p_pkg::cell_data_t    dout
);
    import a2p_pkg::*;

    cell_data_t d_next;
    cell_data_t d_reg;
    logic vld_reg;
    logic [MAG_WIDTH+1:0] trial;
    logic [QW-1:0] r;

    always_comb
    begin
        d_next = din;
        trial = {1'b0, din.rem} - {2'b00, din.hi};
        r = '0;
        case (op)
            OP_DIV:
            begin
                // Restoring division, one quotient bit per cell. The remainder is kept
                // doubled, so the first cell decides the integer bit of the ratio.
                if (!trial[MAG_WIDTH+1] && din.hi != '0)
                begin
                    d_next.rem = {trial[MAG_WIDTH-1:0], 1'b0};
                    d_next.quo = {din.quo[RATIO_WIDTH-2:0], 1'b1};
                end
                else
                begin
                    d_next.rem = {din.rem[MAG_WIDTH-1:0], 1'b0};
                    d_next.quo = {din.quo[RATIO_WIDTH-2:0], 1'b0};
                end
            end
            OP_SQ:
            begin
                d_next.big_a = QW'({din.quo, 14'b0});
                d_next.s = qmul(QW'({din.quo, 14'b0}), QW'({din.quo, 14'b0}));
                d_next.acc = K_C3;
            end
            OP_P1: d_next.acc = qmul(din.acc, din.s) + K_C2;
            OP_P2: d_next.acc = qmul(din.acc, din.s) + K_C1;
            OP_P3: d_next.acc = qmul(din.acc, din.s);
            OP_T:  d_next.acc = qmul(din.acc, din.big_a);
            OP_SUM:
            begin
                r = din.big_a + din.acc;
                if (din.swap)
                    r = K_HALF_PI - r;
                if (din.xneg)
                    r = K_PI - r;
                d_next.acc = r;
            end
            OP_FOLD:
            begin
                r = (din.acc + QW'(1 << (30 - ANGLE_FRAC_BITS - 1))) >> (30 - ANGLE_FRAC_BITS);
                d_next.acc = din.yneg ? -r : r;
            end
            default: d_next = din;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= d_next.vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            d_reg <= d_next;
    end

    always_comb
    begin
        dout = d_reg;
        dout.vld = vld_reg;
    end
endmodule

### src/atan2_polynomial.sv
// Top level of the pipelined four-quadrant arctangent.
//
// s_axis carries one coordinate word per transfer: tdata holds x_coord in
// bits 15:0 and y_coord in bits 31:16, both two's complement. m_axis returns
// one angle word per input word, signed Q3.13 in radians, in [-pi, pi].
// The block is a chain of 24 cells: 17 restoring divider cells form the
// ratio min/max one quotient bit each, then seven cells square the ratio,
// run the Horner steps of the polynomial and apply the quadrant folds.
// A word passes through every cell's register in turn, and a new word is
// taken in every cycle unless the chain is frozen. The whole chain
// advances together: when the receiver stalls and the last cell holds a
// word, the chain freezes, empty slots included, and s_axis_tready drops.
// Reset clears every valid bit, so the output is empty afterwards. There
// is no configuration and no state beyond the words in flight.
`timescale 1ns / 1ps
`include "atan2_polynomial_assert.svh"
module atan2_polynomial (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // x_coord [15:0], y_coord [31:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // angle [15:0]
);
    import a2p_pkg::*;

    cell_data_t chain [NUM_CELLS+1];
    cell_data_t in_word;
    logic en;
    logic signed [COORD_WIDTH-1:0] xc;
    logic signed [COORD_WIDTH-1:0] yc;
    logic [MAG_WIDTH-1:0] ax;
    logic [MAG_WIDTH-1:0] ay;
    logic out_stall;
    logic angle_in_range;

    assign en = !chain[NUM_CELLS].vld || m_axis_tready;
    assign s_axis_tready = en;
    assign xc = s_axis_tdata[15:0];
    assign yc = s_axis_tdata[31:16];
    assign ax = xc[COORD_WIDTH-1] ? MAG_WIDTH'(-xc) : MAG_WIDTH'(xc);
    assign ay = yc[COORD_WIDTH-1] ? MAG_WIDTH'(-yc) : MAG_WIDTH'(yc);

    always_comb
    begin
        in_word = '0;
        in_word.vld = s_axis_tvalid;
        in_word.xneg = xc[COORD_WIDTH-1];
        in_word.yneg = yc[COORD_WIDTH-1];
        in_word.swap = ay > ax;
        in_word.hi = (ay > ax) ? ay : ax;
        in_word.rem = {1'b0, (ay > ax) ? ax : ay};
    end

    assign chain[0] = in_word;

    genvar g;
    generate
        for (g = 0; g < NUM_CELLS; g++)
        begin : g_cell
            cell_op_t op;
            assign op = (g < DIV_STEPS) ? OP_DIV : cell_op_t'(3'(g - DIV_STEPS + 1));
            a2p_cell u_cell (
                .clk  (clk),
                .rst_n(rst_n),
                .en   (en),
                .op   (op),
                .din  (chain[g]),
                .dout (chain[g+1])
            );
        end
    endgenerate

    assign m_axis_tvalid = chain[NUM_CELLS].vld;
    assign m_axis_tdata = chain[NUM_CELLS].acc[15:0];

    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign angle_in_range = ($signed(m_axis_tdata) <= 16'sd25736)
                         && ($signed(m_axis_tdata) >= -16'sd25736);

    `A2P_ASSERT_NEXT(a_hold, clk, rst_n, out_stall, m_axis_tvalid && $stable(m_axis_tdata))
    `A2P_ASSERT_IMPL(a_ready, clk, rst_n, !m_axis_tvalid, s_axis_tready)
    `A2P_ASSERT_IMPL(a_range, clk, rst_n, m_axis_tvalid, angle_in_range)
endmodule
